@@ hdl/lzwd_pkg.sv @@
package lzwd_pkg;

   localparam int HIST_DEPTH      = 256;
   localparam int HIST_AW         = 8;
   localparam int DATA_BITS       = 64;
   localparam int EXP_LEN_BITS    = 24;
   localparam int DEF_BYTES_PER_RESULT = 8;
   localparam int DEF_COUNT_BITS  = 24;

   localparam logic CMD_LITERAL = 1'b0;
   localparam logic CMD_COPY    = 1'b1;

   localparam logic [2:0] REG_EXPECTED_LENGTH = 3'd0;

   // classified token handed from front to back
   typedef struct packed {
      logic       is_copy;
      logic [7:0] lit;
      logic [7:0] off_m1;
      logic [7:0] len_m1;
      logic       fin;
   } token_type;

endpackage

@@ hdl/lzwd_front.sv @@
module lzwd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic                 in_cmd,
   input  logic [23:0]          in_data,
   input  logic                 in_fin,
   output logic                 tok_valid,
   input  logic                 tok_pop,
   output lzwd_pkg::token_type  tok
);
   import lzwd_pkg::*;

   token_type  q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   token_type  cls;
   logic       push;

   // classify: a literal is a one-byte run
   always_comb begin
      cls.is_copy = (in_cmd == CMD_COPY);
      cls.lit     = in_data[7:0];
      cls.off_m1  = in_data[15:8];
      cls.len_m1  = cls.is_copy ? in_data[23:16] : 8'd0;
      cls.fin     = in_fin;
   end

   assign in_ready  = (cnt_ff != 2'd2);
   assign push      = in_valid && in_ready;
   assign tok_valid = (cnt_ff != 2'd0);
   assign tok       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push;
      rd_ptr_in = rd_ptr_ff + tok_pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, tok_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // store the item
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_max: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("token queue over capacity");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      tok_pop |-> cnt_ff != 2'd0) else $error("pop from empty token queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !tok_pop) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count lost a push");
`endif
endmodule

@@ hdl/lzwd_back.sv @@
module lzwd_back #(
   parameter int BYTES_PER_RESULT = lzwd_pkg::DEF_BYTES_PER_RESULT,
   parameter int COUNT_BITS       = lzwd_pkg::DEF_COUNT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 tok_valid,
   output logic                                 tok_pop,
   input  lzwd_pkg::token_type                  tok,
   input  logic [lzwd_pkg::EXP_LEN_BITS-1:0]    expected_length,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [lzwd_pkg::DATA_BITS-1:0]       out_bytes,
   output logic [3:0]                           out_count,
   output logic                                 out_last,
   output logic                                 out_mismatch,
   output logic                                 out_done
);
   import lzwd_pkg::*;

   localparam int LANE_W = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;
   localparam int CMP_W  = (COUNT_BITS > EXP_LEN_BITS) ? COUNT_BITS : EXP_LEN_BITS;
   localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(BYTES_PER_RESULT - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_BYTE, ST_EMIT} state_type;

   state_type             state_ff;
   token_type             cur_ff;
   logic [7:0]            rem_ff;
   logic [LANE_W-1:0]     lane_ff;
   logic [DATA_BITS-1:0]  word_ff;
   logic [HIST_AW-1:0]    wp_ff;
   logic [COUNT_BITS-1:0] cnt_ff;
   logic [HIST_DEPTH-1:0] vld_ff;
   logic                  rd_vld_ff;
   logic [7:0]            rd_data_ff;
   logic [7:0]            hist_mem [HIST_DEPTH];
   logic [HIST_AW-1:0]    rd_addr;
   logic [7:0]            cur_byte;
   logic                  out_free;
   logic                  mismatch;

   logic                  out_valid_ff;
   logic [DATA_BITS-1:0]  out_bytes_ff;
   logic [3:0]            out_count_ff;
   logic                  out_last_ff, out_mismatch_ff, out_done_ff;

   assign rd_addr  = wp_ff - cur_ff.off_m1 - HIST_AW'(1);
   assign cur_byte = cur_ff.is_copy ? (rd_vld_ff ? rd_data_ff : 8'd0) : cur_ff.lit;
   assign out_free = !out_valid_ff || out_ready;
   assign tok_pop  = (state_ff == ST_IDLE) && tok_valid;
   assign mismatch = CMP_W'(cnt_ff) != CMP_W'(expected_length);

   // history ring: one write, one registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= hist_mem[rd_addr];
      if (state_ff == ST_BYTE) begin
         hist_mem[wp_ff] <= cur_byte;
      end
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         cnt_ff       <= '0;
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
         lane_ff      <= '0;
         word_ff      <= '0;
      end else begin
         rd_vld_ff <= vld_ff[rd_addr];
         // drop the result once taken, unless a new one is loaded
         if (out_valid_ff && out_ready && state_ff != ST_EMIT) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (tok_valid) begin
                  cur_ff   <= tok;
                  rem_ff   <= tok.len_m1;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_BYTE;
            end
            ST_BYTE: begin
               vld_ff[wp_ff] <= 1'b1;
               wp_ff         <= wp_ff + HIST_AW'(1);
               if (cnt_ff != '1) begin
                  cnt_ff <= cnt_ff + COUNT_BITS'(1);
               end
               word_ff[32'(lane_ff) * 8 +: 8] <= cur_byte;
               if (lane_ff == LANE_LAST || rem_ff == 8'd0) begin
                  state_ff <= ST_EMIT;
               end else begin
                  lane_ff  <= lane_ff + LANE_W'(1);
                  rem_ff   <= rem_ff - 8'd1;
                  state_ff <= ST_READ;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  out_valid_ff    <= 1'b1;
                  out_bytes_ff    <= word_ff;
                  out_count_ff    <= 4'(lane_ff) + 4'd1;
                  out_last_ff     <= (rem_ff == 8'd0);
                  out_done_ff     <= (rem_ff == 8'd0) && cur_ff.fin;
                  out_mismatch_ff <= (rem_ff == 8'd0) && cur_ff.fin && mismatch;
                  lane_ff         <= '0;
                  word_ff         <= '0;
                  if (rem_ff == 8'd0) begin
                     if (cur_ff.fin) begin
                        cnt_ff <= '0;
                        wp_ff  <= '0;
                     end
                     state_ff <= ST_IDLE;
                  end else begin
                     rem_ff   <= rem_ff - 8'd1;
                     state_ff <= ST_READ;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign out_valid    = out_valid_ff;
   assign out_bytes    = out_bytes_ff;
   assign out_count    = out_count_ff;
   assign out_last     = out_last_ff;
   assign out_mismatch = out_mismatch_ff;
   assign out_done     = out_done_ff;

`ifndef ASSERT_OFF
   a_mis_done: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_mismatch) |-> out_done) else $error("mismatch without stream end");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_done) |-> out_last) else $error("stream end not on last result");
   a_count_rng: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_count != 4'd0 && 32'(out_count) <= BYTES_PER_RESULT))
      else $error("byte count out of range");
   a_ptr_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && rem_ff == 8'd0 && cur_ff.fin) |=> wp_ff == '0)
      else $error("write pointer not cleared at stream end");
`endif
endmodule

@@ hdl/lz_window_decompressor.sv @@
// channel | ports | tdata (low bit up)                     | tuser / tlast
// in      | req_* | literal_byte, offset_m1, length_m1     | tuser=cmd, tlast=final_token
// out     | rsp_* | out_bytes                              | tuser=byte_count, size_mismatch,
//         |       |                                        | stream_done; tlast=last_of_token
// cfg     | csr_* | expected_length at byte address 0      | APB write, pready tied high
//
// Each output byte passes a history read state, then a write state; each result adds an
// emit state. The states are separate because the registered history read must see the
// byte written just before it on a short-offset copy. Reset clears history (per-entry
// valid bits), pointer and count at once.
// Either side may stall: a two-item token queue and a result register decouple the
// input from the output.
module lz_window_decompressor #(
   parameter int BYTES_PER_RESULT = lzwd_pkg::DEF_BYTES_PER_RESULT,
   parameter int COUNT_BITS       = lzwd_pkg::DEF_COUNT_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // literal_byte, offset_minus_one, length_minus_one
   input  logic        req_tuser,   // cmd
   input  logic        req_tlast,   // final_token
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // out_bytes
   output logic [5:0]  rsp_tuser,   // byte_count[3:0], size_mismatch, stream_done
   output logic        rsp_tlast,   // last_of_token
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lzwd_pkg::*;

   logic [EXP_LEN_BITS-1:0] exp_len_ff;
   logic                    tok_valid, tok_pop;
   token_type               tok;
   logic [3:0]              out_count;
   logic                    out_mismatch, out_done;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_EXPECTED_LENGTH) ? 32'(exp_len_ff) : 32'd0;

   // register write
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_len_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr == REG_EXPECTED_LENGTH) begin
         exp_len_ff <= csr_pwdata[EXP_LEN_BITS-1:0];
      end
   end

   lzwd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (req_tuser),
      .in_data   (req_tdata),
      .in_fin    (req_tlast),
      .tok_valid (tok_valid),
      .tok_pop   (tok_pop),
      .tok       (tok)
   );

   lzwd_back #(
      .BYTES_PER_RESULT (BYTES_PER_RESULT),
      .COUNT_BITS       (COUNT_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .tok_valid       (tok_valid),
      .tok_pop         (tok_pop),
      .tok             (tok),
      .expected_length (exp_len_ff),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_bytes       (rsp_tdata),
      .out_count       (out_count),
      .out_last        (rsp_tlast),
      .out_mismatch    (out_mismatch),
      .out_done        (out_done)
   );

   assign rsp_tuser = {out_done, out_mismatch, out_count};
endmodule

@@ tb/lz_window_decompressor_tb.sv @@
module lz_window_decompressor_tb;
   import lzwd_pkg::*;

   typedef struct {
      logic       cmd;
      logic [7:0] lit;
      logic [7:0] off_m1;
      logic [7:0] len_m1;
      logic       fin;
   } tb_token_type;

   typedef struct {
      logic [63:0] bytes;
      logic [3:0]  count;
      logic        last;
      logic        mismatch;
      logic        done;
   } chunk_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [5:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // token stream waiting for the driver and bytes expected back
   tb_token_type token_q[$];
   chunk_type    chunk_q[$];
   int     errors;
   bit     hold_off;

   // model state
   logic [7:0]  hist[256];
   logic [7:0]  wr_ptr;
   logic [23:0] produced;
   logic [23:0] exp_len;

   lz_window_decompressor u_top (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // expand one accepted token into expected output chunks
   task automatic expand_token(input tb_token_type t);
      int total;
      int done_n;
      int chunk;
      logic [7:0] b;
      chunk_type c;
      total  = t.cmd == CMD_COPY ? int'(t.len_m1) + 1 : 1;
      done_n = 0;
      while (done_n < total) begin
         chunk   = total - done_n > 8 ? 8 : total - done_n;
         c.bytes = '0;
         for (int k = 0; k < chunk; k++) begin
            b = t.cmd == CMD_COPY ? hist[8'(wr_ptr - t.off_m1 - 8'd1)] : t.lit;
            hist[wr_ptr] = b;
            wr_ptr++;
            if (produced != 24'hFFFFFF) produced++;
            c.bytes[8*k +: 8] = b;
         end
         done_n    += chunk;
         c.count    = 4'(chunk);
         c.last     = done_n == total;
         c.mismatch = c.last && t.fin && produced != exp_len;
         c.done     = c.last && t.fin;
         chunk_q.push_back(c);
      end
      if (t.fin) begin
         produced = '0;
         wr_ptr   = '0;
      end
   endtask

   // sender: bursts with random gaps
   int gap_left;
   int burst_left;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
         burst_left <= 0;
      end else begin
         if (req_tvalid && req_tready) expand_token(token_q.pop_front());
         if (req_tvalid && !req_tready) begin
            // hold current item
         end else if (token_q.size() > 0 && !hold_off && gap_left == 0) begin
            tb_token_type n;
            n = token_q[0];
            req_tvalid <= 1'b1;
            req_tdata  <= {n.len_m1, n.off_m1, n.lit};
            req_tuser  <= n.cmd;
            req_tlast  <= n.fin;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(0, 12);
               gap_left   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end
      end
   end

   // receiver: stall pattern of its own, plus quiet stretches
   int stall_phase;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         if (stall_phase[8]) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 9) < 6) && (stall_phase % 7 != 3);
      end
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      chunk_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (chunk_q.size() == 0) begin
            $error("unexpected result bytes=%h", rsp_tdata);
            errors++;
         end else begin
            e = chunk_q.pop_front();
            if (rsp_tdata !== e.bytes) begin
               $error("out_bytes exp %h got %h", e.bytes, rsp_tdata);
               errors++;
            end
            if (rsp_tuser[3:0] !== e.count) begin
               $error("byte_count exp %0d got %0d", e.count, rsp_tuser[3:0]);
               errors++;
            end
            if (rsp_tuser[4] !== e.mismatch) begin
               $error("size_mismatch exp %b got %b", e.mismatch, rsp_tuser[4]);
               errors++;
            end
            if (rsp_tuser[5] !== e.done) begin
               $error("stream_done exp %b got %b", e.done, rsp_tuser[5]);
               errors++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last_of_token exp %b got %b", e.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   task automatic add_token(input logic cmd, input logic [7:0] lit, input logic [7:0] off,
                            input logic [7:0] len, input logic fin);
      tb_token_type t;
      t.cmd    = cmd;
      t.lit    = lit;
      t.off_m1 = off;
      t.len_m1 = len;
      t.fin    = fin;
      token_q.push_back(t);
   endtask

   // wait until all items are sent and every result has come
   task automatic drain();
      while (token_q.size() != 0 || req_tvalid || chunk_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_len(input logic [23:0] v);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= REG_EXPECTED_LENGTH;
      csr_pwdata  <= {8'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      exp_len = v;
   endtask

   // random stream ending in a final token; length counted so some match
   task automatic random_stream(input int n_tok, output int bytes);
      logic cmd;
      logic [7:0] len;
      bytes = 0;
      for (int i = 0; i < n_tok; i++) begin
         cmd = $urandom_range(0, 2) != 0;
         len = $urandom_range(0, 5) == 0 ? 8'($urandom) : 8'($urandom_range(0, 20));
         add_token(cmd, 8'($urandom), 8'($urandom), len, i == n_tok - 1);
         bytes += cmd ? int'(len) + 1 : 1;
      end
   endtask

   initial begin
      int n;
      int sent;
      errors      = 0;
      hold_off    = 1'b0;
      reset       = 1'b1;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      foreach (hist[i]) hist[i] = '0;
      wr_ptr   = '0;
      produced = '0;
      exp_len  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: copy before stream start, extremes, overlap, offset 256
      write_len(24'd0);
      add_token(CMD_COPY, 8'hFF, 8'd0, 8'd3, 1'b0);
      add_token(CMD_LITERAL, 8'h00, 8'hFF, 8'hFF, 1'b0);
      add_token(CMD_LITERAL, 8'hFF, 8'h00, 8'h00, 1'b0);
      add_token(CMD_LITERAL, 8'hA5, 8'h00, 8'h00, 1'b0);
      add_token(CMD_COPY, 8'h00, 8'd1, 8'd20, 1'b0);
      add_token(CMD_COPY, 8'h5A, 8'd0, 8'd255, 1'b0);
      add_token(CMD_COPY, 8'h00, 8'd255, 8'd7, 1'b0);
      add_token(CMD_COPY, 8'h00, 8'd255, 8'd8, 1'b1);
      drain();
      // matching length, then leftover history read from previous stream
      write_len(24'd11);
      add_token(CMD_LITERAL, 8'h3C, 8'h00, 8'h00, 1'b0);
      add_token(CMD_COPY, 8'h00, 8'd200, 8'd9, 1'b1);
      drain();
      write_len(24'hFFFFFF);
      add_token(CMD_LITERAL, 8'h81, 8'h00, 8'h00, 1'b1);
      drain();

      // random streams; expected length matches about half the time
      sent = 0;
      while (sent < 150) begin
         hold_off = 1'b1;
         n = $urandom_range(1, 15);
         random_stream(n, n);
         write_len($urandom_range(0, 1) ? 24'(n) : 24'($urandom));
         hold_off = 1'b0;
         sent += token_q.size();
         drain();
      end

      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("Verification failed");
      $finish;
   end

endmodule
